>>> hw/rtl/swt_pkg.sv
// Shared types and character codes for the shell word tokenizer.
package swt_pkg;

    // Token kinds as they appear on the output channel.
    typedef enum logic [2:0] {
        KIND_CHAR = 3'd0,
        KIND_WEND = 3'd1,
        KIND_ROUT = 3'd2,
        KIND_APP  = 3'd3,
        KIND_RERR = 3'd4,
        KIND_EOL  = 3'd5
    } kind_t;

    // Held lookahead of the front end.
    typedef enum logic [2:0] {
        LA_NONE  = 3'd0,
        LA_ESC   = 3'd1,
        LA_DQESC = 3'd2,
        LA_GT    = 3'd3,
        LA_TWO   = 3'd4
    } la_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] word_char;
    } tok_t;

    // All tokens caused by one input byte; cnt is 1 to 3 when queued.
    typedef struct packed {
        logic [1:0]     cnt;
        tok_t [2:0]     tok;
    } bundle_t;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_TWO     = 8'h32;

    // Default depth of the bundle queue between front and back end.
    localparam int SWT_QDEPTH = 2;

endpackage

>>> hw/rtl/swt_if.sv
// Channel interfaces: command line bytes in, tokens out.
interface swt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface swt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] word_char;
    logic       last_of_run;

    modport source (output valid, output kind, output word_char, output last_of_run,
                     input ready);
    modport sink   (input valid, input kind, input word_char, input last_of_run,
                    output ready);
endinterface

>>> hw/rtl/swt_front.sv
// Front end: lexes one byte per cycle, while the queue has room, into a bundle of up to three tokens.
module swt_front import swt_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    swt_in_if.sink        line,
    output logic          push_valid,
    input  logic          push_ready,
    output bundle_t       push_data
);

    typedef struct packed {
        logic sq;
        logic dq;
        logic wo;
        la_t  la;
    } lex_st_t;

    typedef struct packed {
        lex_st_t st;
        bundle_t b;
    } work_t;

    lex_st_t st_reg, st_next;
    work_t   w;
    logic    accept;

    function automatic work_t put(work_t wi, kind_t k, logic [7:0] c);
        work_t r;
        r = wi;
        if (r.b.cnt != 2'd3)
        begin
            r.b.tok[r.b.cnt].kind      = k;
            r.b.tok[r.b.cnt].word_char = (k == KIND_CHAR) ? c : 8'h00;
            r.b.cnt                    = r.b.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic work_t put_char(work_t wi, logic [7:0] c);
        work_t r;
        r      = put(wi, KIND_CHAR, c);
        r.st.wo = 1'b1;
        return r;
    endfunction

    function automatic work_t close_word(work_t wi);
        work_t r;
        r = wi;
        if (r.st.wo)
        begin
            r      = put(r, KIND_WEND, 8'h00);
            r.st.wo = 1'b0;
        end
        return r;
    endfunction

    // Unescaped byte, no lookahead pending.
    function automatic work_t plain(work_t wi, logic [7:0] c);
        work_t r;
        r = wi;
        if (r.st.sq)
        begin
            if (c == CH_SQUOTE)
                r.st.sq = 1'b0;
            else
                r = put_char(r, c);
        end
        else if (r.st.dq)
        begin
            if (c == CH_DQUOTE)
                r.st.dq = 1'b0;
            else if (c == CH_BSLASH)
                r.st.la = LA_DQESC;
            else
                r = put_char(r, c);
        end
        else if (c inside {CH_SPACE, CH_TAB})
            r = close_word(r);
        else if (c == CH_BSLASH)
            r.st.la = LA_ESC;
        else if (c == CH_GT)
        begin
            r       = close_word(r);
            r.st.la = LA_GT;
        end
        else if (c == CH_TWO)
            r.st.la = LA_TWO;
        else if (c == CH_SQUOTE)
        begin
            r.st.sq = 1'b1;
            r.st.wo = 1'b1;
        end
        else if (c == CH_DQUOTE)
        begin
            r.st.dq = 1'b1;
            r.st.wo = 1'b1;
        end
        else
            r = put_char(r, c);
        return r;
    endfunction

    always_comb
    begin
        w       = '0;
        w.st    = st_reg;
        w.st.la = LA_NONE;
        if (line.is_end)
        begin
            case (st_reg.la)
                LA_DQESC: w = put_char(w, CH_BSLASH);
                LA_GT:    w = put(w, KIND_ROUT, 8'h00);
                LA_TWO:   w = put_char(w, CH_TWO);
                default:  ;
            endcase
            w    = close_word(w);
            w    = put(w, KIND_EOL, 8'h00);
            w.st = '0;
        end
        else
        begin
            case (st_reg.la)
                LA_ESC:
                    w = put_char(w, line.ch);
                LA_DQESC:
                begin
                    if (line.ch inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR})
                        w = put_char(w, line.ch);
                    else
                    begin
                        w = put_char(w, CH_BSLASH);
                        w = plain(w, line.ch);
                    end
                end
                LA_GT:
                begin
                    if (line.ch == CH_GT)
                        w = put(w, KIND_APP, 8'h00);
                    else
                    begin
                        w = put(w, KIND_ROUT, 8'h00);
                        w = plain(w, line.ch);
                    end
                end
                LA_TWO:
                begin
                    if (line.ch == CH_GT)
                    begin
                        w = close_word(w);
                        w = put(w, KIND_RERR, 8'h00);
                    end
                    else
                    begin
                        w = put_char(w, CH_TWO);
                        w = plain(w, line.ch);
                    end
                end
                default:
                    w = plain(w, line.ch);
            endcase
        end
    end

    assign line.ready = push_ready;
    assign accept     = line.valid && push_ready;
    assign push_valid = accept && (w.b.cnt != 2'd0);
    assign push_data  = w.b;
    assign st_next    = accept ? w.st : st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

endmodule

>>> hw/rtl/swt_queue.sv
// Small FIFO of token bundles between front and back end.
module swt_queue import swt_pkg::*; #(
    parameter int DEPTH = SWT_QDEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  bundle_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output bundle_t pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hw/rtl/swt_back.sv
// Back end: plays out one token per cycle from the current bundle while the output is ready.
module swt_back import swt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  bundle_t   pop_data,
    swt_out_if.source tokens
);

    bundle_t    cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       last, fire;
    tok_t       t;

    assign t    = cur_reg.tok[idx_reg];
    assign last = (idx_reg == cur_reg.cnt - 2'd1);
    assign fire = cur_valid_reg && tokens.ready;

    // Take the next bundle when idle or when the final token goes out.
    assign pop_ready = !cur_valid_reg || (fire && last);

    assign tokens.valid       = cur_valid_reg;
    assign tokens.kind        = t.kind;
    assign tokens.word_char   = t.word_char;
    assign tokens.last_of_run = last;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop_ready)
        begin
            cur_next       = pop_data;
            cur_valid_next = pop_valid;
            idx_next       = 2'd0;
        end
        else if (fire)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

>>> hw/rtl/shell_word_tokenizer.sv
// Top level of the shell word tokenizer: front end, bundle queue, back end.
//
// Streaming lexer for a shell command line. One byte is taken per transaction on
// "line"; is_end marks the end of the line (ch is then ignored). Tokens leave on
// "tokens" one per transaction: word bytes (kind 0), word end (1), '>' (2),
// '>>' (3), '2>' (4) and end of line (5); last_of_run flags the final token
// caused by one input byte. Bytes that cause no token (quotes, blanks between
// words, a held backslash, '>' or '2') produce no transaction. Rate: the front
// end takes one byte every cycle while the queue has room; each byte yields
// zero to three tokens, and the back end emits one token per cycle while the
// output is ready, so the output port sets the sustained rate at one token per
// cycle. An accepted byte is written into the queue, then loaded by the back
// end, before its first token leaves. The queue holds QDEPTH bundles and lets
// the input run on while tokens of earlier bytes wait on a stalled output.
module shell_word_tokenizer import swt_pkg::*; #(
    parameter int QDEPTH = SWT_QDEPTH  // bundles in flight between front and back, >= 2
) (
    input  logic      clk,
    input  logic      rst_n,
    swt_in_if.sink    line,
    swt_out_if.source tokens
);

    logic    push_valid, push_ready;
    logic    pop_valid, pop_ready;
    bundle_t push_data, pop_data;

    // Lexer state and token generation.
    swt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .line       (line),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouples byte intake from token playout.
    swt_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Serializes each bundle onto the output channel.
    swt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .tokens    (tokens)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("bundle pushed into full queue");

    // A queued bundle always carries at least one token.
    a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_data.cnt != 2'd0))
        else $error("empty bundle queued");

    // End of line always produces a bundle.
    a_eol_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (line.valid && line.ready && line.is_end) |-> push_valid)
        else $error("end of line produced no tokens");

    // The end marker is always the final token of its byte.
    a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && (tokens.kind == KIND_EOL)) |-> tokens.last_of_run)
        else $error("end marker not flagged last");

endmodule

>>> sim/shell_word_tokenizer_tb.sv
// Self-checking testbench for the shell word tokenizer: directed table, then random lines.
module shell_word_tokenizer_tb;
    import swt_pkg::*;

    // One token as the output channel carries it.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] wc;
        logic       last;
    } tok_s;

    // Directed stimulus row; n < 0 means the lexer model supplies the tokens,
    // otherwise t[0..n-1] are the tokens typed in by hand.
    typedef struct {
        logic [7:0] c;
        logic       e;
        int         n;
        tok_s       t [3];
    } stim_row_s;

    logic clk = 1'b0;
    logic rst_n;

    swt_in_if  line_bus();
    swt_out_if tok_bus();

    shell_word_tokenizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .line   (line_bus),
        .tokens (tok_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer model: quoting modes, open-word flag and the one-byte lookahead.
    // ------------------------------------------------------------------
    logic       sq_open;
    logic       dq_open;
    logic       word_live;
    la_t        held;
    tok_s       lex_out [3];
    int         lex_n;

    // Tokens still owed by the DUT, oldest first.
    tok_s       tok_expect [$];
    int         mismatches = 0;
    // Raised by the stimulus side to ask the token sink for one long hold-off.
    bit         tokens_hold_req = 1'b0;

    stim_row_s  dir_rows [$];
    logic [7:0] line_q [$];

    function automatic tok_s tk(kind_t k, logic [7:0] w, logic l);
        tok_s t;
        t.kind = k;
        t.wc   = w;
        t.last = l;
        return t;
    endfunction

    function void lex_emit(kind_t k, logic [7:0] c);
        if (lex_n < 3)
        begin
            lex_out[lex_n] = tk(k, (k == KIND_CHAR) ? c : 8'h00, 1'b0);
            lex_n++;
        end
    endfunction

    function void lex_char(logic [7:0] c);
        lex_emit(KIND_CHAR, c);
        word_live = 1'b1;
    endfunction

    function void lex_close_word();
        if (word_live)
        begin
            lex_emit(KIND_WEND, 8'h00);
            word_live = 1'b0;
        end
    endfunction

    function void lex_reset();
        sq_open   = 1'b0;
        dq_open   = 1'b0;
        word_live = 1'b0;
        held      = LA_NONE;
    endfunction

    // A byte with no lookahead pending.
    function void lex_plain(logic [7:0] c);
        if (sq_open)
        begin
            if (c == CH_SQUOTE)
                sq_open = 1'b0;
            else
                lex_char(c);
        end
        else if (dq_open)
        begin
            if (c == CH_DQUOTE)
                dq_open = 1'b0;
            else if (c == CH_BSLASH)
                held = LA_DQESC;
            else
                lex_char(c);
        end
        else if (c == CH_SPACE || c == CH_TAB)
            lex_close_word();
        else if (c == CH_BSLASH)
            held = LA_ESC;
        else if (c == CH_GT)
        begin
            lex_close_word();
            held = LA_GT;
        end
        else if (c == CH_TWO)
            held = LA_TWO;
        else if (c == CH_SQUOTE)
        begin
            sq_open   = 1'b1;
            word_live = 1'b1;
        end
        else if (c == CH_DQUOTE)
        begin
            dq_open   = 1'b1;
            word_live = 1'b1;
        end
        else
            lex_char(c);
    endfunction

    // Advance the model by one accepted byte; tokens land in lex_out[0..lex_n-1].
    function void lex_byte(logic [7:0] c, logic e);
        la_t prev;
        prev  = held;
        lex_n = 0;
        held  = LA_NONE;
        if (e)
        begin
            // end of line resolves whatever is held, closes the word, resets
            case (prev)
                LA_DQESC: lex_char(CH_BSLASH);
                LA_GT:    lex_emit(KIND_ROUT, 8'h00);
                LA_TWO:   lex_char(CH_TWO);
                default:  ;
            endcase
            lex_close_word();
            lex_emit(KIND_EOL, 8'h00);
            lex_reset();
        end
        else
        begin
            case (prev)
                LA_ESC:
                    lex_char(c);
                LA_DQESC:
                    if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR)
                        lex_char(c);
                    else
                    begin
                        lex_char(CH_BSLASH);
                        lex_plain(c);
                    end
                LA_GT:
                    if (c == CH_GT)
                        lex_emit(KIND_APP, 8'h00);
                    else
                    begin
                        lex_emit(KIND_ROUT, 8'h00);
                        lex_plain(c);
                    end
                LA_TWO:
                    if (c == CH_GT)
                    begin
                        lex_close_word();
                        lex_emit(KIND_RERR, 8'h00);
                    end
                    else
                    begin
                        lex_char(CH_TWO);
                        lex_plain(c);
                    end
                default:
                    lex_plain(c);
            endcase
        end
        if (lex_n > 0)
            lex_out[lex_n - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none, some short, a few long; none at all in a burst.
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        else
            return $urandom_range(15, 30);
    endfunction

    function void add_row(logic [7:0] c, logic e, int n = -1,
                          tok_s t0 = '0, tok_s t1 = '0, tok_s t2 = '0);
        stim_row_s r;
        r.c    = c;
        r.e    = e;
        r.n    = n;
        r.t[0] = t0;
        r.t[1] = t1;
        r.t[2] = t2;
        dir_rows.push_back(r);
    endfunction

    // Random byte that is not a separator, quote, escape or operator byte.
    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_SPACE || b == CH_TAB || b == CH_SQUOTE || b == CH_DQUOTE ||
            b == CH_BSLASH || b == CH_GT || b == CH_TWO)
            b = "a" + b[3:0];
        return b;
    endfunction

    // Fill line_q with one command line (without its end marker). Most lines are
    // well formed with random content; some are raw noise or end in a dangling quote,
    // escape or operator.
    function void build_line();
        int         pieces;
        int         len;
        logic [7:0] b;
        line_q.delete();
        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(1, 10);
            repeat (len)
                line_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        pieces = $urandom_range(1, 6);
        repeat (pieces)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    len = $urandom_range(1, 5);
                    repeat (len)
                        line_q.push_back(word_byte());
                end
                1:
                begin
                    len = $urandom_range(1, 2);
                    repeat (len)
                        line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                end
                2:
                begin
                    line_q.push_back(CH_SQUOTE);
                    len = $urandom_range(0, 4);
                    repeat (len)
                    begin
                        b = 8'($urandom_range(0, 255));
                        line_q.push_back(b == CH_SQUOTE ? CH_DQUOTE : b);
                    end
                    line_q.push_back(CH_SQUOTE);
                end
                3:
                begin
                    line_q.push_back(CH_DQUOTE);
                    len = $urandom_range(0, 4);
                    repeat (len)
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_BSLASH || b == CH_DQUOTE || $urandom_range(0, 3) == 0)
                        begin
                            // escape: one of the three escapable bytes or any other
                            line_q.push_back(CH_BSLASH);
                            case ($urandom_range(0, 3))
                                0:       b = CH_DQUOTE;
                                1:       b = CH_BSLASH;
                                2:       b = CH_DOLLAR;
                                default: b = word_byte();
                            endcase
                        end
                        line_q.push_back(b);
                    end
                    line_q.push_back(CH_DQUOTE);
                end
                4:
                begin
                    line_q.push_back(CH_BSLASH);
                    line_q.push_back(8'($urandom_range(0, 255)));
                end
                5:
                    line_q.push_back(CH_GT);
                6:
                begin
                    line_q.push_back(CH_GT);
                    line_q.push_back(CH_GT);
                end
                7:
                begin
                    line_q.push_back(CH_TWO);
                    line_q.push_back(CH_GT);
                end
                8:
                begin
                    line_q.push_back(CH_TWO);
                    line_q.push_back($urandom_range(0, 1) ? word_byte() : CH_TWO);
                end
                default:
                    case ($urandom_range(0, 3))
                        0:       line_q.push_back(CH_SQUOTE);
                        1:       line_q.push_back(CH_DQUOTE);
                        2:       line_q.push_back(CH_BSLASH);
                        default:
                        begin
                            line_q.push_back(CH_GT);
                            line_q.push_back(CH_GT);
                            line_q.push_back(CH_GT);
                        end
                    endcase
            endcase
        end
    endfunction

    // Present one byte and hold it until the DUT takes it.
    task automatic offer_byte(input logic [7:0] c, input logic e, input int gap);
        if (gap > 0)
        begin
            line_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        line_bus.ch     <= c;
        line_bus.is_end <= e;
        line_bus.valid  <= 1'b1;
        do
            @(posedge clk);
        while (line_bus.ready !== 1'b1);
    endtask

    function void push_lexed();
        for (int k = 0; k < lex_n; k++)
            tok_expect.push_back(lex_out[k]);
    endfunction

    task automatic feed(input logic [7:0] c, input logic e, input int gap);
        offer_byte(c, e, gap);
        lex_byte(c, e);
        push_lexed();
    endtask

    // ------------------------------------------------------------------
    // Token sink: random back-pressure, plus one long hold-off on request so
    // the bundle queue fills and the line input stalls.
    // ------------------------------------------------------------------
    initial
    begin
        int  run;
        int  stall;
        bit  burst;
        tok_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (tokens_hold_req)
            begin
                tok_bus.ready <= 1'b0;
                repeat (100) @(posedge clk);
                tokens_hold_req = 1'b0;
            end
            burst = ($urandom_range(0, 9) == 0);
            run   = burst ? $urandom_range(30, 60) : $urandom_range(1, 8);
            stall = pick_gap(1'b0);
            tok_bus.ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (stall > 0)
            begin
                tok_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Token checker: every accepted token against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : tok_check
        tok_s want;
        if (rst_n && tok_bus.valid === 1'b1 && tok_bus.ready === 1'b1)
        begin
            if (tok_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: kind %0d char %02h last %b",
                             tok_bus.kind, tok_bus.word_char, tok_bus.last_of_run);
            end
            else
            begin
                want = tok_expect.pop_front();
                if (tok_bus.kind !== want.kind || tok_bus.word_char !== want.wc ||
                    tok_bus.last_of_run !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("token mismatch: want kind %0d char %02h last %b, %s",
                                 want.kind, want.wc, want.last,
                                 $sformatf("got kind %0d char %02h last %b",
                                           tok_bus.kind, tok_bus.word_char,
                                           tok_bus.last_of_run));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int         rand_sent;
        bit         burst;
        bit         drained;
        logic [7:0] eol_ch;

        rand_sent = 0;
        drained   = 1'b0;
        line_bus.valid  <= 1'b0;
        line_bus.ch     <= 8'h00;
        line_bus.is_end <= 1'b0;
        rst_n <= 1'b0;
        lex_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: byte extremes, blanks, '>' / '>>' / '>>>', '2>' after a
        // word, escapes in and out of double quotes, empty quotes, and end of line
        // resolving a held '2', backslash and '>'.
        add_row("a", 1'b0, 1, tk(KIND_CHAR, "a", 1'b1));
        add_row(8'hFF, 1'b0, 1, tk(KIND_CHAR, 8'hFF, 1'b1));
        add_row(CH_SPACE, 1'b0, 1, tk(KIND_WEND, 8'h00, 1'b1));
        add_row(8'h00, 1'b0);
        add_row(CH_TAB, 1'b0);
        add_row(CH_GT, 1'b0);           // nothing yet, '>' held
        add_row(CH_GT, 1'b0);           // append
        add_row(CH_GT, 1'b0);           // third '>' held again
        add_row("x", 1'b0);             // redirect out, then the byte
        add_row(CH_TWO, 1'b0);
        add_row(CH_GT, 1'b0);           // word closed before stderr redirect
        add_row(CH_DQUOTE, 1'b0);
        add_row(CH_BSLASH, 1'b0);
        add_row(CH_DOLLAR, 1'b0);       // escaped dollar
        add_row(CH_BSLASH, 1'b0);
        add_row("n", 1'b0);             // backslash stays literal
        add_row(CH_DQUOTE, 1'b0);
        add_row(CH_SQUOTE, 1'b0);
        add_row(CH_DQUOTE, 1'b0);       // literal inside single quotes
        add_row(CH_SQUOTE, 1'b0);
        add_row(CH_TWO, 1'b0);
        // held '2' at end of line: byte, word end, end marker
        add_row(8'hFF, 1'b1, 3, tk(KIND_CHAR, CH_TWO, 1'b0),
                tk(KIND_WEND, 8'h00, 1'b0), tk(KIND_EOL, 8'h00, 1'b1));
        add_row(CH_SQUOTE, 1'b0);
        add_row(CH_SQUOTE, 1'b0);       // empty argument
        add_row(CH_BSLASH, 1'b0);
        // trailing backslash dropped, empty word still closed
        add_row(8'h00, 1'b1, 2, tk(KIND_WEND, 8'h00, 1'b0), tk(KIND_EOL, 8'h00, 1'b1));
        add_row(CH_GT, 1'b0);
        add_row(8'h5A, 1'b1);           // held '>' flushed at end of line

        foreach (dir_rows[i])
        begin
            offer_byte(dir_rows[i].c, dir_rows[i].e, pick_gap(1'b0));
            lex_byte(dir_rows[i].c, dir_rows[i].e);
            if (dir_rows[i].n < 0)
                push_lexed();
            else
                for (int k = 0; k < dir_rows[i].n; k++)
                    tok_expect.push_back(dir_rows[i].t[k]);
        end

        // Random lines; the sink is asked for a long hold-off right away while
        // bytes keep coming, and halfway the input pauses until all tokens are out.
        tokens_hold_req = 1'b1;
        while (rand_sent < 380)
        begin
            burst = ($urandom_range(0, 3) == 0);
            build_line();
            foreach (line_q[i])
            begin
                feed(line_q[i], 1'b0, pick_gap(burst));
                rand_sent++;
            end
            // a few lines run on into the next without an end marker
            if ($urandom_range(0, 7) != 0)
            begin
                eol_ch = 8'($urandom_range(0, 255));
                feed(eol_ch, 1'b1, pick_gap(burst));
                rand_sent++;
            end
            if (!drained && rand_sent > 190)
            begin
                line_bus.valid <= 1'b0;
                @(posedge clk);
                while (tok_expect.size() != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
        end

        line_bus.valid <= 1'b0;
        while (tok_expect.size() != 0)
            @(posedge clk);
        // let any stray token show up
        repeat (20) @(posedge clk);

        if (mismatches == 0 && tok_expect.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
